// File: rtl/row_convolution_narrow_wide_assert.svh
// Assertion macros used by the row convolution sequencer (rcnw_ctrl).
`ifndef ROW_CONVOLUTION_NARROW_WIDE_ASSERT_SVH
`define ROW_CONVOLUTION_NARROW_WIDE_ASSERT_SVH

// Condition must hold on every clock out of reset.
`define RCNW_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rcnw assertion failed");

// When the first condition holds, the second must hold on the next clock.
`define RCNW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcnw assertion failed");

`endif

// File: rtl/rcnw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnw_pkg
// Shared types and constants of the row convolution block.
// ----------------------------------------------------------------------------
package rcnw_pkg;

  localparam int MAX_TAPS   = 16;
  localparam int TAP_W      = 4;
  localparam int TC_W       = 5;
  localparam int ROW_W      = 6;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int RES_W      = 36;
  localparam int COL_W      = 9;
  localparam int COEF_AW    = ROW_W + TAP_W;
  localparam int COEF_DEPTH = 1 << COEF_AW;

  localparam logic [COL_W-1:0] CNT_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE = 2'd1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic write_coef;
    logic mac_start;
    logic mac_issue;
    logic push;
    logic flush_shift;
    logic clear_row;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic end_q;
    logic mac_last;
    logic pipe_empty;
    logic out_free;
    logic more_flush;
  } dp_sts_t;

endpackage

// File: rtl/row_convolution_narrow_wide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_convolution_narrow_wide
// Per-row 1-D narrow or wide convolution, Q4.12 in, Q12.24 out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): kind 1 writes one coefficient
//    {row_index, tap_index} into the coefficient RAM. kind 0 is a
//    sample; row_start opens a row, row_end closes it.
//  - Output channel (out_valid / out_stall): one item per result with
//    row, column and row_done on the last result of the row.
//  - Config (cfg_valid / cfg_ready, always ready): index 0 tap_count,
//    index 1 wide_mode. Write only while idle.
//  - One shared multiply-accumulate walks the T taps, one tap per cycle,
//    through a RAM read, a product register and the accumulator.
//    A sample that emits runs one MAC pass and its result goes to the
//    output register; the block takes no new item until it is idle again.
//    A sample that emits nothing returns to idle after its check. Each
//    wide flush result adds one more MAC pass.
//  - A finished result waits in the output register; the block accepts
//    new items meanwhile and only holds a later result until it drains.
//  - Reset clears the window, counters, current row and config
//    (tap_count 1, narrow). Coefficients are undefined until written.
// ----------------------------------------------------------------------------
module row_convolution_narrow_wide import rcnw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    kind,
  input  logic [ROW_W-1:0]        row_index,
  input  logic [TAP_W-1:0]        tap_index,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    row_start,
  input  logic                    row_end,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] result,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_column,
  output logic                    row_done
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // config registers take a write on any cycle
  assign cfg_ready = 1'b1;

  rcnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcnw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .row_index  (row_index),
    .tap_index  (tap_index),
    .value      (value),
    .row_start  (row_start),
    .row_end    (row_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .out_row    (out_row),
    .out_column (out_column),
    .row_done   (row_done)
  );

endmodule

// File: rtl/rcnw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnw_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcnw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rcnw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnw_ctrl
// Sequencer: accepts items, runs the tap MAC passes and the wide flush.
// ----------------------------------------------------------------------------
`include "row_convolution_narrow_wide_assert.svh"

module rcnw_ctrl import rcnw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     kind,
  output logic     in_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (kind == KIND_COEF) begin
            cmd.write_coef = 1'b1;
          end else begin
            cmd.take_sample = 1'b1;
            state_next      = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.emit_ok) begin
          cmd.mac_start = 1'b1;
          state_next    = ST_MAC;
        end else begin
          cmd.clear_row = sts.end_q;
          state_next    = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (sts.mac_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty && sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.more_flush) begin
            cmd.flush_shift = 1'b1;
            cmd.mac_start   = 1'b1;
            state_next      = ST_MAC;
          end else begin
            cmd.clear_row = sts.end_q;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `RCNW_ASSERT_ALWAYS(a_push_safe, clk, rst, !cmd.push || (sts.pipe_empty && sts.out_free))
  `RCNW_ASSERT_ALWAYS(a_start_empty, clk, rst, !cmd.mac_start || sts.pipe_empty)
  `RCNW_ASSERT_NEXT(a_mac_exit, clk, rst, state == ST_MAC,
                    state == ST_MAC || state == ST_DRAIN)
  `RCNW_ASSERT_NEXT(a_sample_busy, clk, rst, cmd.take_sample, in_stall)

endmodule

// File: rtl/rcnw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnw_datapath
// Config registers, sample window, coefficient RAM, MAC and output register.
// ----------------------------------------------------------------------------
module rcnw_datapath import rcnw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_cmd_t                cmd,
  output dp_sts_t                 sts,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [ROW_W-1:0]        row_index,
  input  logic [TAP_W-1:0]        tap_index,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    row_start,
  input  logic                    row_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] result,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_column,
  output logic                    row_done
);

  logic [TC_W-1:0]   tap_count;
  logic              wide_mode;
  logic [TAP_W-1:0]  tm1;            // taps in use minus one
  logic [VAL_W-1:0]  win [MAX_TAPS];
  logic [COL_W-1:0]  samples_seen;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  cur_row;
  logic              end_q;
  logic [TAP_W-1:0]  flush_i;
  logic [TAP_W-1:0]  k;
  logic              iss_v;
  logic              mul_v;
  logic signed [VAL_W-1:0]  win_q;
  logic signed [VAL_W-1:0]  coef_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [RES_W-1:0]  acc;
  logic              done_now;

  // clamp: 0 acts as 1, above MAX_TAPS acts as MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      tm1 = '0;
    end else if (tap_count > TC_W'(MAX_TAPS)) begin
      tm1 = TAP_W'(MAX_TAPS - 1);
    end else begin
      tm1 = TAP_W'(tap_count - TC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TC_W'(1);
      wide_mode <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_TAP_COUNT) begin
        tap_count <= cfg_data;
      end else if (cfg_index == CFG_WIDE_MODE) begin
        wide_mode <= cfg_data[0];
      end
    end
  end

  // sample window, index 0 newest
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_row) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.take_sample || cmd.flush_shift) begin
      for (int i = 1; i < MAX_TAPS; i++) begin
        win[i] <= (cmd.take_sample && row_start) ? '0 : win[i-1];
      end
      win[0] <= cmd.take_sample ? value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_row) begin
      samples_seen <= '0;
    end else if (cmd.take_sample) begin
      if (row_start) begin
        samples_seen <= COL_W'(1);
      end else if (samples_seen != CNT_MAX) begin
        samples_seen <= samples_seen + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_row) begin
      column <= '0;
    end else if (cmd.take_sample && row_start) begin
      column <= '0;
    end else if (cmd.push && column != CNT_MAX) begin
      column <= column + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      end_q   <= 1'b0;
      flush_i <= '0;
    end else begin
      if (cmd.take_sample) begin
        if (row_start) begin
          cur_row <= row_index;
        end
        end_q   <= row_end;
        flush_i <= '0;
      end else if (cmd.flush_shift) begin
        flush_i <= flush_i + TAP_W'(1);
      end
    end
  end

  rcnw_ram #(
    .WIDTH (VAL_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cmd.write_coef),
    .waddr ({row_index, tap_index}),
    .wdata (value),
    .raddr ({cur_row, k}),
    .rdata (coef_q)
  );

  // MAC pipe: issue -> RAM read / window pick -> product -> accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      iss_v <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      if (cmd.mac_start) begin
        k <= '0;
      end else if (cmd.mac_issue) begin
        k <= k + TAP_W'(1);
      end
      iss_v <= cmd.mac_issue;
      mul_v <= iss_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      win_q <= win[tm1 - k];    // tap 0 meets the oldest sample
    end
    prod <= coef_q * win_q;
    if (cmd.mac_start) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + {{(RES_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign done_now = end_q && (!wide_mode || flush_i == tm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result     <= acc;
      out_row    <= cur_row;
      out_column <= column;
      row_done   <= done_now;
    end
  end

  always_comb begin
    sts.emit_ok    = wide_mode || (samples_seen >= COL_W'(tm1) + COL_W'(1));
    sts.end_q      = end_q;
    sts.mac_last   = (k == tm1);
    sts.pipe_empty = !iss_v && !mul_v;
    sts.out_free   = !out_valid || !out_stall;
    sts.more_flush = wide_mode && end_q && (flush_i != tm1);
  end

endmodule
